/* src/ifmt_pkg.sv */
// ----------------------------------------------------------------------------
// ifmt_pkg: shared types and constants for the integer to ASCII formatter
// Request and result structs, the job record passed from front to back,
// format codes and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int unsigned MAX_WIDTH   = 63;
  localparam int unsigned DIGIT_SLOTS = 11;
  localparam int unsigned DIG_BITS    = DIGIT_SLOTS * 4;
  localparam int unsigned NDIG_W      = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned FIFO_DEPTH  = 2;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Format codes
  localparam logic [1:0] MODE_SDEC  = 2'd0;
  localparam logic [1:0] MODE_UDEC  = 2'd1;
  localparam logic [1:0] MODE_HEXLC = 2'd2;
  localparam logic [1:0] MODE_HEXUC = 2'd3;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  mode;
    logic [5:0]  min_chars;
    logic        pad_zero;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_req_t;

  // One formatted number: digits stored most significant in the top slot
  typedef struct packed {
    logic [DIG_BITS-1:0] digits;
    logic [NDIG_W-1:0]   ndig;
    logic                negative;
    logic                pad_zero;
    logic                upper;
    logic [5:0]          width;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER : CH_LOWER;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

/* src/integer_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 32-bit integer to ASCII text
// Formats a number as signed/unsigned decimal or hex with left padding,
// one character per result, marking the final character.
// ----------------------------------------------------------------------------
//  channel | handshake     | payload                               | note
//  --------+---------------+---------------------------------------+-----------------
//  item    | push / full   | value, mode, min_chars, pad_zero      | one number
//  result  | pop / empty   | out_char, last                        | 1..63 per number
//
//  The front takes a request only when idle, forms each decimal digit by a
//  reciprocal multiply and then a remainder, or each hex digit directly, and
//  then queues the job, so it takes no new request before the job is queued.
//  The back loads a job and then emits one character per accepted pop,
//  max(min_chars, length) characters; the slower half sets the sustained rate and
//  the two-entry job queue lets both halves stall separately.
//  rst is synchronous and empties both halves and the queue.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ifmt_pkg::in_req_t  item,
  output logic               empty,
  input  logic               pop,
  output ifmt_pkg::out_req_t result
);
  import ifmt_pkg::*;

  logic job_wr;
  logic job_rd;
  logic job_full;
  logic job_empty;
  job_t job_w;
  job_t job_r;

  ifmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_wr   (job_wr),
    .job_out  (job_w),
    .job_full (job_full)
  );

  ifmt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_wr),
    .wr_data (job_w),
    .q_full  (job_full),
    .rd      (job_rd),
    .rd_data (job_r),
    .q_empty (job_empty)
  );

  ifmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job_r),
    .job_empty (job_empty),
    .job_rd    (job_rd),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

/* src/ifmt_front.sv */
// ----------------------------------------------------------------------------
// ifmt_front: request intake and digit generation
// Takes one request, forms the magnitude and peels off one digit per step
// (a decimal digit through a reciprocal multiply and then a remainder, a hex
// digit directly), then hands the finished job to the queue.
// ----------------------------------------------------------------------------
module ifmt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ifmt_pkg::in_req_t item,
  output logic             job_wr,
  output ifmt_pkg::job_t   job_out,
  input  logic             job_full
);
  import ifmt_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIG  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t     state, state_next;
  logic [31:0] mag;
  logic [63:0] prod;
  logic        dec;
  job_t        job;

  logic        in_neg;
  logic [31:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;
  logic [3:0]  rem;

  // Sign of the incoming value
  assign in_neg = (item.mode == MODE_SDEC) && item.value[31];

  // One digit step
  always_comb begin
    quot_x10 = '0;
    rem_full = '0;
    if (dec) begin
      quot     = {3'b0, prod[63:RECIP_SHIFT]};
      quot_x10 = (quot << 3) + (quot << 1);
      rem_full = mag - quot_x10;
      rem      = rem_full[3:0];
    end else begin
      quot = {4'b0, mag[31:4]};
      rem  = mag[3:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (push) begin
          state_next = (item.mode == MODE_SDEC || item.mode == MODE_UDEC) ? F_MUL : F_DIG;
        end
      end
      F_MUL: state_next = F_DIG;
      F_DIG: begin
        if (quot == '0) begin
          state_next = F_PUSH;
        end else begin
          state_next = dec ? F_MUL : F_DIG;
        end
      end
      F_PUSH: begin
        if (!job_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (push) begin
          mag          <= in_neg ? (32'd0 - item.value) : item.value;
          dec          <= (item.mode == MODE_SDEC) || (item.mode == MODE_UDEC);
          job.digits   <= '0;
          job.ndig     <= '0;
          job.negative <= in_neg;
          job.pad_zero <= item.pad_zero;
          job.upper    <= (item.mode == MODE_HEXUC);
          job.width    <= (32'(item.min_chars) > MAX_WIDTH) ? 6'(MAX_WIDTH) : item.min_chars;
        end
      end
      F_MUL: prod <= 64'(mag) * 64'(RECIP10);
      F_DIG: begin
        // newest digit is the most significant so far: it goes on top
        job.digits <= {rem, job.digits[DIG_BITS-1:4]};
        job.ndig   <= job.ndig + 1'b1;
        mag        <= quot;
      end
      default: ;
    endcase
  end

  assign full    = (state != F_IDLE);
  assign job_wr  = (state == F_PUSH) && !job_full;
  assign job_out = job;

  // Checks
  a_ndig_bound: assert property (@(posedge clk) disable iff (rst)
    (state != F_IDLE) |-> 32'(job.ndig) <= DIGIT_SLOTS)
    else $error("front: digit count beyond slot count");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_wr |-> job.ndig != '0)
    else $error("front: job pushed with no digits");

endmodule

/* src/ifmt_fifo.sv */
// ----------------------------------------------------------------------------
// ifmt_fifo: short job queue between front and back
// Two-entry queue of formatted jobs; lets digit generation of the next
// request overlap the character output of the current one.
// ----------------------------------------------------------------------------
module ifmt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ifmt_pkg::job_t wr_data,
  output logic           q_full,
  input  logic           rd,
  output ifmt_pkg::job_t rd_data,
  output logic           q_empty
);
  import ifmt_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  job_t               mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];
  assign q_full  = (32'(count) == FIFO_DEPTH);
  assign q_empty = (count == '0);

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= FIFO_DEPTH)
    else $error("fifo: fill level out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && q_full))
    else $error("fifo: write while full");

endmodule

/* src/ifmt_back.sv */
// ----------------------------------------------------------------------------
// ifmt_back: character sequencer
// Pulls one job from the queue and emits its characters: the sign ahead of zero
// padding or after space padding, then the digits, one per accepted result request.
// ----------------------------------------------------------------------------
module ifmt_back (
  input  logic               clk,
  input  logic               rst,
  input  ifmt_pkg::job_t     job_in,
  input  logic               job_empty,
  output logic               job_rd,
  output ifmt_pkg::out_req_t result,
  output logic               empty,
  input  logic               pop
);
  import ifmt_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_SIGNA = 5'b00010,  // sign ahead of zero padding
    B_PAD   = 5'b00100,
    B_SIGNB = 5'b01000,  // sign after space padding
    B_DIG   = 5'b10000
  } bstate_t;

  bstate_t             state, state_next;
  logic [DIG_BITS-1:0] digits;
  logic [NDIG_W-1:0]   dig_cnt;
  logic [5:0]          pad_cnt;
  logic                negative;
  logic                pad_zero;
  logic                upper;

  logic [5:0] body;
  logic [5:0] pad;
  logic       take;

  // Padding length for the job at the queue head
  assign body = 6'(job_in.ndig) + 6'(job_in.negative);
  assign pad  = (job_in.width > body) ? (job_in.width - body) : 6'd0;
  assign take = pop && !empty;

  assign job_rd = (state == B_IDLE) && !job_empty;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          if (job_in.negative && job_in.pad_zero) begin
            state_next = B_SIGNA;
          end else if (pad != '0) begin
            state_next = B_PAD;
          end else if (job_in.negative) begin
            state_next = B_SIGNB;
          end else begin
            state_next = B_DIG;
          end
        end
      end
      B_SIGNA: begin
        if (take) begin
          state_next = (pad_cnt != '0) ? B_PAD : B_DIG;
        end
      end
      B_PAD: begin
        if (take && pad_cnt == 6'd1) begin
          state_next = (negative && !pad_zero) ? B_SIGNB : B_DIG;
        end
      end
      B_SIGNB: begin
        if (take) begin
          state_next = B_DIG;
        end
      end
      B_DIG: begin
        if (take && dig_cnt == NDIG_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job registers and counters
  always_ff @(posedge clk) begin
    if (job_rd) begin
      digits   <= job_in.digits;
      dig_cnt  <= job_in.ndig;
      pad_cnt  <= pad;
      negative <= job_in.negative;
      pad_zero <= job_in.pad_zero;
      upper    <= job_in.upper;
    end else if (take) begin
      if (state == B_PAD) begin
        pad_cnt <= pad_cnt - 1'b1;
      end
      if (state == B_DIG) begin
        digits  <= {digits[DIG_BITS-5:0], 4'h0};
        dig_cnt <= dig_cnt - 1'b1;
      end
    end
  end

  // Current character
  always_comb begin
    result.last = 1'b0;
    case (state)
      B_SIGNA, B_SIGNB: result.out_char = CH_MINUS;
      B_PAD:            result.out_char = pad_zero ? CH_ZERO : CH_SPACE;
      B_DIG: begin
        result.out_char = digit_char(digits[DIG_BITS-1 -: 4], upper);
        result.last     = (dig_cnt == NDIG_W'(1));
      end
      default:          result.out_char = CH_SPACE;
    endcase
  end

  assign empty = (state == B_IDLE);

  // Checks
  a_dig_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIG) |-> dig_cnt != '0)
    else $error("back: digit phase with no digits left");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (take && result.last) |=> state == B_IDLE)
    else $error("back: output continued after last character");

endmodule
